@@ src/bsc_pkg.sv @@
package bsc_pkg;

    // fixed field widths
    localparam int BITMAP_W = 64;
    localparam int COUNT_W  = 16;
    localparam int INDEX_W  = 32;
    localparam int CAND_W   = 9;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SELF_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WORDS_DROP = 1'b1;

    // incoming hit request
    typedef struct packed {
        logic                first_hit;
        logic [BITMAP_W-1:0] hit_bitmap;
        logic [COUNT_W-1:0]  word_count;
        logic [INDEX_W-1:0]  target_index;
    } hit_t;

    // outgoing filter verdict
    typedef struct packed {
        logic               kept;
        logic               skipped_self;
        logic               covered;
        logic               table_overflow;
        logic [INDEX_W-1:0] echo_index;
        logic [CAND_W-1:0]  candidate_count;
    } res_t;

endpackage

@@ src/bsc_stream_if.sv @@
interface bsc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

@@ src/bitmap_superset_candidate_filter.sv @@
// Bitmap superset candidate filter.
// Hits come in on the hit channel (valid/ready), sorted by falling word
// count; one verdict per hit leaves on the res channel (valid/ready).
// A hit is kept and its bitmap stored unless a stored bitmap holds all of
// its bits, self mode skips it (word count above the ceiling) or the table
// is full; first_hit empties the table and loads the self-mode ceiling.
// Configuration (self_mode, words_drop) is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while no request is in
// flight, as the block itself does not enforce this.
// A skipped hit or an empty table goes straight to the verdict. Else the
// scan reads the stored bitmaps (at most TABLE_DEPTH) in order until a
// superset is found or all are read; the table memory has a single read
// port, so the scan reads one stored bitmap per cycle. hit.ready is low
// while a hit is being worked on. A new hit is taken once the previous
// verdict is in the output register, even while the receiver stalls; the
// next verdict waits until that register is taken.
// Reset empties the table, zeroes the ceiling and both registers, and
// drops any pending result; the table memory itself is not cleared.
module bitmap_superset_candidate_filter #(
    parameter int TABLE_DEPTH = 256,
    parameter int MAP_BITS    = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bsc_stream_if.sink                hit,
    bsc_stream_if.source              res,
    input  logic                      cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsc_pkg::CFG_W-1:0] cfg_data
);
    import bsc_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic                self_mode_reg;
    logic [COUNT_W-1:0]  words_drop_reg;
    logic [COUNT_W-1:0]  ceiling_reg, ceiling_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       idx_inc;
    logic [MAP_BITS-1:0] map_reg, map_next;
    logic [INDEX_W-1:0]  tidx_reg, tidx_next;
    logic                skip_reg, skip_next;
    logic                cover_reg, cover_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg, res_next;

    logic                rd_en;
    logic [MAP_BITS-1:0] rd_data;
    logic                wr_en;
    logic                match;
    logic                out_free;
    logic                table_full;
    logic [COUNT_W-1:0]  ceil_new;
    logic [COUNT_W-1:0]  ceil_eff;
    logic [CW-1:0]       count_eff;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_mode_reg  <= 1'b0;
            words_drop_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SELF_MODE:  self_mode_reg  <= cfg_data[0];
                REG_WORDS_DROP: words_drop_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stored bitmap table
    bsc_kept_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (MAP_BITS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (map_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // shared subset compare
    assign match = ((rd_data & map_reg) == map_reg);

    assign ceil_new   = (hit.payload.word_count > words_drop_reg) ?
                        (hit.payload.word_count - words_drop_reg) : '0;
    assign ceil_eff   = hit.payload.first_hit ? ceil_new : ceiling_reg;
    assign count_eff  = hit.payload.first_hit ? '0 : count_reg;
    assign idx_inc    = idx_reg + 1'b1;
    assign table_full = (count_reg == CW'(TABLE_DEPTH));
    assign out_free   = !res_valid_reg || res.ready;

    assign hit.ready   = (state_reg == ST_IDLE);
    assign res.valid   = res_valid_reg;
    assign res.payload = res_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ceiling_next   = ceiling_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        map_next       = map_reg;
        tidx_next      = tidx_reg;
        skip_next      = skip_reg;
        cover_next     = cover_reg;
        cmp_valid_next = 1'b0;
        res_valid_next = res_valid_reg && !res.ready;
        res_next       = res_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (hit.valid)
                begin
                    map_next   = hit.payload.hit_bitmap[MAP_BITS-1:0];
                    tidx_next  = hit.payload.target_index;
                    idx_next   = '0;
                    cover_next = 1'b0;
                    count_next = count_eff;
                    if (hit.payload.first_hit)
                    begin
                        ceiling_next = ceil_new;
                    end
                    skip_next = self_mode_reg && (hit.payload.word_count > ceil_eff);
                    if (skip_next || count_eff == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (cmp_valid_reg && match)
                begin
                    cover_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    idx_next       = idx_inc;
                    if (idx_inc == count_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end

            ST_DRAIN:
            begin
                if (cmp_valid_reg && match)
                begin
                    cover_next = 1'b1;
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_next.kept           = 1'b0;
                    res_next.skipped_self   = skip_reg;
                    res_next.covered        = cover_reg;
                    res_next.table_overflow = 1'b0;
                    res_next.echo_index     = tidx_reg;
                    res_next.candidate_count = CAND_W'(count_reg);
                    if (!skip_reg && !cover_reg)
                    begin
                        if (table_full)
                        begin
                            res_next.table_overflow = 1'b1;
                        end
                        else
                        begin
                            wr_en                    = 1'b1;
                            count_next               = count_reg + 1'b1;
                            res_next.kept            = 1'b1;
                            res_next.candidate_count = CAND_W'(count_next);
                        end
                    end
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ceiling_reg   <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ceiling_reg   <= ceiling_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        map_reg   <= map_next;
        tidx_reg  <= tidx_next;
        skip_reg  <= skip_next;
        cover_reg <= cover_next;
        res_reg   <= res_next;
    end

    // checks
    a_one_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $onehot({res_reg.kept, res_reg.skipped_self,
                                   res_reg.covered, res_reg.table_overflow}))
        else $error("verdict flags not exclusive");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("table count beyond depth");

    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (hit.valid && hit.ready && hit.payload.first_hit) |=> (count_reg == '0))
        else $error("first hit did not empty table");

    a_keep_grows: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("kept hit did not grow table");
endmodule

@@ src/bsc_kept_mem.sv @@
module bsc_kept_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
